[rtl/core/psr_pkg.sv]
// Shared record type, cell control and coordinate compare for the position record sorter.
package psr_pkg;

	localparam logic [63:0] SIGN_BIT = 64'h8000_0000_0000_0000;
	localparam logic [63:0] EXP_MASK = 64'h7FF0_0000_0000_0000;
	localparam logic [63:0] MAN_MASK = 64'h000F_FFFF_FFFF_FFFF;

	typedef struct packed {
		logic [31:0] tag;
		logic [63:0] z;
		logic [63:0] y;
		logic [63:0] x;
	} record_t;

	typedef struct packed {
		logic load;
		logic drain;
	} cell_ctl_t;

	typedef struct packed {
		logic gt;
		logic lt;
	} cmp_t;

	function automatic logic is_nan(input logic [63:0] v);
		return ((v & EXP_MASK) == EXP_MASK) && ((v & MAN_MASK) != 64'd0);
	endfunction

	function automatic logic [63:0] order_key(input logic [63:0] v);
		logic [63:0] t;
		t = (v == SIGN_BIT) ? 64'd0 : v;
		return t[63] ? ~t : (t | SIGN_BIT);
	endfunction

	// NaN on either side compares as equal
	function automatic cmp_t cmp_coord(input logic [63:0] a, input logic [63:0] b);
		cmp_t r;
		logic [63:0] ka;
		logic [63:0] kb;
		ka = order_key(a);
		kb = order_key(b);
		r.gt = 1'b0;
		r.lt = 1'b0;
		if (!is_nan(a) && !is_nan(b)) begin
			r.gt = ka > kb;
			r.lt = ka < kb;
		end
		return r;
	endfunction

	function automatic logic rec_greater(input record_t s, input record_t n);
		cmp_t cx;
		cmp_t cy;
		cmp_t cz;
		cx = cmp_coord(s.x, n.x);
		cy = cmp_coord(s.y, n.y);
		cz = cmp_coord(s.z, n.z);
		if (cx.gt || cx.lt) return cx.gt;
		if (cy.gt || cy.lt) return cy.gt;
		return cz.gt;
	endfunction

endpackage

[rtl/core/psr_cell.sv]
// One slot of the sorted chain: holds a record and trades it with its neighbors.
module psr_cell
	import psr_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  cell_ctl_t ctl,
	input  record_t   new_rec,
	input  record_t   left_rec,
	input  logic      left_valid,
	input  logic      left_move,
	input  record_t   right_rec,
	input  logic      right_valid,
	input  logic      move_in,
	output logic      move_out,
	output record_t   rec,
	output logic      valid
);

	record_t rec_q;
	logic    valid_q;

	// this slot and every one above it hold greater records or nothing
	assign move_out = (!valid_q || rec_greater(rec_q, new_rec)) && move_in;
	assign rec      = rec_q;
	assign valid    = valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (ctl.drain) begin
			valid_q <= right_valid;
		end else if (ctl.load && move_out && left_valid) begin
			valid_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.drain) begin
			rec_q <= right_rec;
		end else if (ctl.load && move_out && left_valid) begin
			rec_q <= left_move ? left_rec : new_rec;
		end
	end

endmodule

[rtl/core/position_record_sorter.sv]
// Top level of the position record sorter: insertion chain, drain control and output register.
// Loading takes one beat per cycle while s_tready is high; each record drops into place in the cell chain at once.
// After the last-marked beat the chain drains toward cell 0, one result beat per cycle
// while the output side takes them; s_tready is low for that drain.
// The last input beat sets the drain flag, and the first result then moves into the output register.
// arst_n empties the chain and clears the overflow flag; record contents are not reset.
module position_record_sorter
	import psr_pkg::*;
#(
	parameter int MAX_RECORDS = 64
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	output logic         s_tready,
	input  logic [223:0] s_tdata,  // pos_x[63:0], pos_y[127:64], pos_z[191:128], record_tag[223:192]
	input  logic         s_tlast,  // last_record
	output logic         m_tvalid,
	input  logic         m_tready,
	output logic [223:0] m_tdata,  // out_x[63:0], out_y[127:64], out_z[191:128], out_tag[223:192]
	output logic         m_tlast,  // last_result
	output logic         m_tuser   // overflow
);

	record_t   rec_w   [MAX_RECORDS+1];
	logic      valid_w [MAX_RECORDS+1];
	logic      move_w  [MAX_RECORDS+1];
	record_t   new_rec;
	cell_ctl_t ctl;
	logic      drain_q;
	logic      ovf_q;
	logic      in_beat;
	logic      full;
	logic      out_free;
	record_t   out_rec_q;
	logic      out_valid_q;
	logic      out_last_q;
	logic      out_ovf_q;

	assign new_rec  = record_t'(s_tdata);
	assign s_tready = !drain_q;
	assign in_beat  = s_tvalid && s_tready;
	assign full     = valid_w[MAX_RECORDS-1];
	assign out_free = !out_valid_q || m_tready;

	// load only with room; drain shifts one slot each time the output register frees
	assign ctl.load  = in_beat && !full;
	assign ctl.drain = drain_q && out_free && valid_w[0];

	// chain ends: the far end is empty and always accepts a move; cell 0 at the near end is fed the new record
	assign rec_w[MAX_RECORDS]   = '0;
	assign valid_w[MAX_RECORDS] = 1'b0;
	assign move_w[MAX_RECORDS]  = 1'b1;

	for (genvar i = 0; i < MAX_RECORDS; i++) begin : g_cell
		psr_cell u_cell (
			.clk        (clk),
			.arst_n     (arst_n),
			.ctl        (ctl),
			.new_rec    (new_rec),
			.left_rec   ((i == 0) ? new_rec : rec_w[(i == 0) ? 0 : i-1]),
			.left_valid ((i == 0) ? 1'b1 : valid_w[(i == 0) ? 0 : i-1]),
			.left_move  ((i == 0) ? 1'b0 : move_w[(i == 0) ? 0 : i-1]),
			.right_rec  (rec_w[i+1]),
			.right_valid(valid_w[i+1]),
			.move_in    (move_w[i+1]),
			.move_out   (move_w[i]),
			.rec        (rec_w[i]),
			.valid      (valid_w[i])
		);
	end

	// drain flag and overflow flag for the batch
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			drain_q <= 1'b0;
			ovf_q   <= 1'b0;
		end else if (drain_q) begin
			if (!valid_w[0]) begin
				drain_q <= 1'b0;
				ovf_q   <= 1'b0;
			end
		end else if (in_beat) begin
			if (full) ovf_q <= 1'b1;
			if (s_tlast) drain_q <= 1'b1;
		end
	end

	// output register: hold until taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_free) begin
			out_valid_q <= ctl.drain;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.drain) begin
			out_rec_q  <= rec_w[0];
			out_last_q <= !valid_w[1];
			out_ovf_q  <= ovf_q;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_rec_q;
	assign m_tlast  = out_last_q;
	assign m_tuser  = out_ovf_q;

	a_front_packed: assert property (@(posedge clk) disable iff (!arst_n)
		valid_w[1] |-> valid_w[0])
		else $error("chain has a hole at the front");

	a_last_starts_drain: assert property (@(posedge clk) disable iff (!arst_n)
		(in_beat && s_tlast) |=> drain_q)
		else $error("last beat did not start drain");

	a_drain_ends: assert property (@(posedge clk) disable iff (!arst_n)
		(drain_q && !valid_w[0]) |=> !drain_q)
		else $error("drain did not end on empty chain");

endmodule
